FILE: rtl/assert_macros.svh
// Assertion helpers shared by the rotation core RTL.
// Define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/vaxr_pkg.sv
package vaxr_pkg;

  // Rotation axis codes
  localparam logic [1:0] CMD_ROT_X = 2'd0;
  localparam logic [1:0] CMD_ROT_Y = 2'd1;
  localparam logic [1:0] CMD_ROT_Z = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam int CORDIC_STEPS = 31;
  localparam int CW = 34;   // CORDIC datapath width, Q2.30 plus headroom
  localparam int RW = 36;   // reduced angle width, Q.30

  // Angle constants in Q.30
  localparam logic signed [RW-1:0] TWO_PI    = 36'sh1921FB544;
  localparam logic signed [RW-1:0] PI        = 36'sh0C90FDAA2;
  localparam logic signed [RW-1:0] HALF_PI   = 36'sh06487ED51;
  localparam logic signed [RW-1:0] PI_3_HALF = TWO_PI - HALF_PI;

  // floor(2^62 / TWO_PI): quotient estimate is (angle_q16 * RECIP) >> 48
  localparam logic [29:0] RECIP = 30'((64'd1 << 62) / 64'h1921FB544);

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    logic [1:0] command;
    q16_t       x;
    q16_t       y;
    q16_t       z;
  } vec_t;

  // reduced angle handed to the CORDIC
  typedef struct packed {
    vec_t               vec;
    logic               neg;
    logic signed [31:0] z;
  } angle_t;

  // sine and cosine in Q2.30
  typedef struct packed {
    vec_t               vec;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } trig_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h3243F6A8;
      5'd1:    a = 32'h1DAC6705;
      5'd2:    a = 32'h0FADBAFC;
      5'd3:    a = 32'h07F56EA6;
      5'd4:    a = 32'h03FEAB76;
      5'd5:    a = 32'h01FFD55B;
      5'd6:    a = 32'h00FFFAAA;
      5'd7:    a = 32'h007FFF55;
      5'd8:    a = 32'h003FFFEA;
      5'd9:    a = 32'h001FFFFD;
      5'd10:   a = 32'h000FFFFF;
      5'd11:   a = 32'h0007FFFF;
      5'd12:   a = 32'h0003FFFF;
      5'd13:   a = 32'h0001FFFF;
      5'd14:   a = 32'h0000FFFF;
      5'd15:   a = 32'h00007FFF;
      5'd16:   a = 32'h00003FFF;
      5'd17:   a = 32'h00001FFF;
      5'd18:   a = 32'h00000FFF;
      5'd19:   a = 32'h000007FF;
      5'd20:   a = 32'h000003FF;
      5'd21:   a = 32'h000001FF;
      5'd22:   a = 32'h000000FF;
      5'd23:   a = 32'h0000007F;
      5'd24:   a = 32'h0000003F;
      5'd25:   a = 32'h0000001F;
      5'd26:   a = 32'h0000000F;
      5'd27:   a = 32'h00000008;
      5'd28:   a = 32'h00000004;
      5'd29:   a = 32'h00000002;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return {{(CW-32){1'b0}}, a};
  endfunction

endpackage

FILE: rtl/vaxr_angle_reduce.sv
`include "assert_macros.svh"

// Angle reduction: Q16.16 radians -> Q2.30 in [-pi/2, pi/2] plus sign flag.
// Five stages: reciprocal multiply, quotient times 2pi, remainder,
// remainder correction, quadrant fold.
module vaxr_angle_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  vaxr_pkg::vec_t     up_vec,
  input  logic signed [31:0] up_angle,
  output logic               dn_valid,
  input  logic               dn_ready,
  output vaxr_pkg::angle_t   dn_data
);

  localparam int NS = 5;
  localparam int RW = vaxr_pkg::RW;
  localparam logic signed [30:0] RECIP_S = $signed({1'b0, vaxr_pkg::RECIP});

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  vaxr_pkg::vec_t     vec0, vec1, vec2, vec3, vec4;
  logic signed [31:0] ang0, ang1;
  logic signed [62:0] prod0;
  logic signed [49:0] qt1;
  logic signed [RW-1:0] r2, r3;
  logic signed [31:0] z4;
  logic               neg4;

  logic signed [62:0]   prod_next;
  logic signed [14:0]   q_est;
  logic signed [49:0]   qt_next;
  logic signed [49:0]   w1;
  logic signed [RW-1:0] r0_next;
  logic signed [RW-1:0] r_next;
  logic signed [31:0]   z_next;
  logic                 neg_next;

  // a stage loads when it is empty or its content moves on
  assign en[NS-1] = !vld[NS-1] || dn_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // quotient estimate, off by at most one
  assign prod_next = 63'(up_angle) * 63'(RECIP_S);
  assign q_est     = prod0[62:48];
  assign qt_next   = 50'(q_est) * 50'(vaxr_pkg::TWO_PI);
  assign w1        = 50'(ang1) <<< 14;
  assign r0_next   = RW'(w1 - qt1);

  always_comb begin
    if (r2 < 0) begin
      r_next = r2 + vaxr_pkg::TWO_PI;
    end else if (r2 >= vaxr_pkg::TWO_PI) begin
      r_next = r2 - vaxr_pkg::TWO_PI;
    end else begin
      r_next = r2;
    end
  end

  // [0, 2pi) -> [-pi/2, pi/2]; the middle band is turned by pi
  always_comb begin
    if (r3 <= vaxr_pkg::HALF_PI) begin
      z_next   = 32'(r3);
      neg_next = 1'b0;
    end else if (r3 < vaxr_pkg::PI_3_HALF) begin
      z_next   = 32'(r3 - vaxr_pkg::PI);
      neg_next = 1'b1;
    end else begin
      z_next   = 32'(r3 - vaxr_pkg::TWO_PI);
      neg_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vec0  <= up_vec;
      ang0  <= up_angle;
      prod0 <= prod_next;
    end
    if (en[1]) begin
      vec1 <= vec0;
      ang1 <= ang0;
      qt1  <= qt_next;
    end
    if (en[2]) begin
      vec2 <= vec1;
      r2   <= r0_next;
    end
    if (en[3]) begin
      vec3 <= vec2;
      r3   <= r_next;
    end
    if (en[4]) begin
      vec4 <= vec3;
      z4   <= z_next;
      neg4 <= neg_next;
    end
  end

  assign dn_valid    = vld[NS-1];
  assign dn_data.vec = vec4;
  assign dn_data.neg = neg4;
  assign dn_data.z   = z4;

  `ASSERT_IMPLIES(a_rem_range, clk, rst, vld[3], r3 >= 0 && r3 < vaxr_pkg::TWO_PI, "angle remainder outside [0, 2pi)")
  `ASSERT_IMPLIES(a_fold_range, clk, rst, vld[4], z4 >= vaxr_pkg::HALF_PI * -1 && z4 <= vaxr_pkg::HALF_PI, "folded angle outside [-pi/2, pi/2]")

endmodule

FILE: rtl/vaxr_cordic.sv
`include "assert_macros.svh"

// Rotation-mode CORDIC, one iteration per stage, then a sign stage.
module vaxr_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  vaxr_pkg::angle_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output vaxr_pkg::trig_t  dn_data
);

  localparam int STEPS = vaxr_pkg::CORDIC_STEPS;
  localparam int NS    = STEPS + 1;
  localparam int CW    = vaxr_pkg::CW;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic signed [CW-1:0] xs [STEPS];
  logic signed [CW-1:0] ys [STEPS];
  logic signed [CW-1:0] zs [STEPS];
  vaxr_pkg::vec_t       vecs [STEPS];
  logic                 negs [STEPS];
  vaxr_pkg::trig_t      trig;

  assign en[NS-1] = !vld[NS-1] || dn_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] xi, yi, zi;
    vaxr_pkg::vec_t       vi;
    logic                 ni;

    if (i == 0) begin : g_first
      assign xi = vaxr_pkg::CORDIC_GAIN;
      assign yi = '0;
      assign zi = CW'(up_data.z);
      assign vi = up_data.vec;
      assign ni = up_data.neg;
    end else begin : g_later
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign vi = vecs[i-1];
      assign ni = negs[i-1];
    end

    // arithmetic shifts floor toward minus infinity
    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (zi >= 0) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - vaxr_pkg::atan_q30(5'(i));
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + vaxr_pkg::atan_q30(5'(i));
        end
        vecs[i] <= vi;
        negs[i] <= ni;
      end
    end
  end

  // undo the pi turn of the angle fold
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      trig.vec   <= vecs[STEPS-1];
      trig.cos_v <= 32'(negs[STEPS-1] ? -xs[STEPS-1] : xs[STEPS-1]);
      trig.sin_v <= 32'(negs[STEPS-1] ? -ys[STEPS-1] : ys[STEPS-1]);
    end
  end

  assign dn_valid = vld[NS-1];
  assign dn_data  = trig;

  `ASSERT_IMPLIES(a_cos_fits, clk, rst, vld[STEPS-1], xs[STEPS-1][CW-1:31] == '0 || xs[STEPS-1][CW-1:31] == '1, "cosine exceeds Q2.30 range")
  `ASSERT_IMPLIES(a_sin_fits, clk, rst, vld[STEPS-1], ys[STEPS-1][CW-1:31] == '0 || ys[STEPS-1][CW-1:31] == '1, "sine exceeds Q2.30 range")

endmodule

FILE: rtl/vaxr_rotate.sv
// Plane rotation of the two off-axis components: products, sums, then
// rounding, saturation and placement of the result.
module vaxr_rotate (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  vaxr_pkg::trig_t    up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out
);

  localparam int NS = 3;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  vaxr_pkg::vec_t     vec0, vec1;
  logic signed [63:0] p_ac, p_bs, p_as, p_bc;
  logic signed [64:0] o1, o2;
  logic signed [31:0] xr, yr, zr;

  logic signed [31:0] a_sel, b_sel;
  logic signed [31:0] s1, s2;
  logic signed [31:0] x_next, y_next, z_next;

  function automatic logic signed [31:0] sat_round(input logic signed [64:0] s);
    logic signed [64:0] t;
    t = (s + 65'sd536870912) >>> 30;
    if (t > 65'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (t < -65'sd2147483648) begin
      return 32'sh80000000;
    end
    return t[31:0];
  endfunction

  assign en[NS-1] = !vld[NS-1] || dn_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // first/second = a*c - b*s, a*s + b*c
  always_comb begin
    case (up_data.vec.command)
      vaxr_pkg::CMD_ROT_X: begin
        a_sel = up_data.vec.y;
        b_sel = up_data.vec.z;
      end
      vaxr_pkg::CMD_ROT_Y: begin
        a_sel = up_data.vec.z;
        b_sel = up_data.vec.x;
      end
      vaxr_pkg::CMD_ROT_Z: begin
        a_sel = up_data.vec.x;
        b_sel = up_data.vec.y;
      end
      default: begin
        a_sel = up_data.vec.x;
        b_sel = up_data.vec.y;
      end
    endcase
  end

  assign s1 = sat_round(o1);
  assign s2 = sat_round(o2);

  always_comb begin
    case (vec1.command)
      vaxr_pkg::CMD_ROT_X: begin
        x_next = vec1.x;
        y_next = s1;
        z_next = s2;
      end
      vaxr_pkg::CMD_ROT_Y: begin
        x_next = s2;
        y_next = vec1.y;
        z_next = s1;
      end
      vaxr_pkg::CMD_ROT_Z: begin
        x_next = s1;
        y_next = s2;
        z_next = vec1.z;
      end
      default: begin
        x_next = vec1.x;
        y_next = vec1.y;
        z_next = vec1.z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vec0 <= up_data.vec;
      p_ac <= 64'(a_sel) * 64'(up_data.cos_v);
      p_bs <= 64'(b_sel) * 64'(up_data.sin_v);
      p_as <= 64'(a_sel) * 64'(up_data.sin_v);
      p_bc <= 64'(b_sel) * 64'(up_data.cos_v);
    end
    if (en[1]) begin
      vec1 <= vec0;
      o1   <= 65'(p_ac) - 65'(p_bs);
      o2   <= 65'(p_as) + 65'(p_bc);
    end
    if (en[2]) begin
      xr <= x_next;
      yr <= y_next;
      zr <= z_next;
    end
  end

  assign dn_valid = vld[NS-1];
  assign x_out    = xr;
  assign y_out    = yr;
  assign z_out    = zr;

endmodule

FILE: rtl/vector_axis_rotation_core.sv
// Elementary axis rotation of a Q16.16 vector.
// Request channel (req_valid/req_ready): command picks the axis (x, y, z, or
// none for a plain pass-through), x_in/y_in/z_in the vector, angle_rad the
// angle in Q16.16 radians, reduced modulo 2pi internally.
// Result channel (res_valid/res_ready): x_out/y_out/z_out, the two off-axis
// components rotated right-handed, rounded half up and saturated; the axis
// component passes through exactly.
// Pipeline: 40 register stages (5 angle reduction, 31 CORDIC iterations plus
// a sign stage, 3 for products, sums and rounding). Throughput: one request
// per clock while the result side keeps taking results; the CORDIC stages
// make up most of the pipeline depth, and no stage has more than one
// multiply in series.
// Each stage carries its own valid bit. When the receiver stalls, stages
// ahead of the first empty one hold, and empty stages keep filling, so
// req_ready stays high until every stage is full. Nothing is dropped or
// duplicated.
// Reset (rst, synchronous) clears all valid bits; any data in flight is lost.
`include "assert_macros.svh"

module vector_axis_rotation_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  input  logic signed [31:0] angle_rad,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out
);

  vaxr_pkg::vec_t   req_vec;

  // angle reduction -> CORDIC
  logic             red_valid;
  logic             red_ready;
  vaxr_pkg::angle_t red_data;

  // CORDIC -> rotation
  logic             trig_valid;
  logic             trig_ready;
  vaxr_pkg::trig_t  trig_data;

  assign req_vec.command = command;
  assign req_vec.x       = x_in;
  assign req_vec.y       = y_in;
  assign req_vec.z       = z_in;

  vaxr_angle_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .up_vec   (req_vec),
    .up_angle (angle_rad),
    .dn_valid (red_valid),
    .dn_ready (red_ready),
    .dn_data  (red_data)
  );

  vaxr_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .up_valid (red_valid),
    .up_ready (red_ready),
    .up_data  (red_data),
    .dn_valid (trig_valid),
    .dn_ready (trig_ready),
    .dn_data  (trig_data)
  );

  vaxr_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .up_valid (trig_valid),
    .up_ready (trig_ready),
    .up_data  (trig_data),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .x_out    (x_out),
    .y_out    (y_out),
    .z_out    (z_out)
  );

  // a free output lets every stage advance, so the front must be open
  `ASSERT_IMPLIES(a_ready_chain, clk, rst, res_ready, req_ready, "request side blocked while result side is free")
  // with a free output, items leaving the reduction and the CORDIC find room
  `ASSERT_IMPLIES(a_inner_chain, clk, rst, res_ready, trig_ready && red_ready, "inner stage blocked while result side is free")

endmodule

FILE: tb/sv/rotation_checker.sv
`timescale 1ns / 1ps

module rotation_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  logic [1:0]       command,
  input  vaxr_pkg::q16_t   x_in,
  input  vaxr_pkg::q16_t   y_in,
  input  vaxr_pkg::q16_t   z_in,
  input  vaxr_pkg::q16_t   angle_rad,
  input  logic             res_valid,
  input  logic             res_ready,
  input  vaxr_pkg::q16_t   x_out,
  input  vaxr_pkg::q16_t   y_out,
  input  vaxr_pkg::q16_t   z_out,
  output int               mismatch_count,
  output int               pending,
  output int               results_checked,
  output int               rail_results
);

  typedef struct packed {
    vaxr_pkg::q16_t x;
    vaxr_pkg::q16_t y;
    vaxr_pkg::q16_t z;
  } vec3_t;

  // Q.30 angle constants, CORDIC gain, rounding and saturation limits
  localparam longint TWO_PI_Q30  = 64'sh1_921F_B544;
  localparam longint PI_Q30      = 64'sh0_C90F_DAA2;
  localparam longint HALF_PI_Q30 = 64'sh0_6487_ED51;
  localparam longint GAIN_Q30    = 64'sh0_26DD_3B6A;
  localparam longint ROUND_HALF  = 64'sd536870912;
  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;
  localparam vaxr_pkg::q16_t RAIL_HI = 32'sh7FFF_FFFF;
  localparam vaxr_pkg::q16_t RAIL_LO = 32'sh8000_0000;

  localparam longint ARCTAN_STEP [31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001
  };

  vec3_t expected_vectors [$];
  int    errs;
  int    checked;
  int    rails;

  // sine and cosine in Q2.30; angle folded into [-pi/2, pi/2] first
  function automatic void sine_cosine(input vaxr_pkg::q16_t angle, output longint s,
                                      output longint c);
    longint r, cx, cy, cz, dx, dy;
    logic   flip;
    r = (longint'(angle) * 64'sd16384) % TWO_PI_Q30;
    if (r < 0) r = r + TWO_PI_Q30;
    if (r >= PI_Q30) r = r - TWO_PI_Q30;
    flip = 1'b0;
    if (r > HALF_PI_Q30) begin
      r = r - PI_Q30;
      flip = 1'b1;
    end else if (r < -HALF_PI_Q30) begin
      r = r + PI_Q30;
      flip = 1'b1;
    end
    cx = GAIN_Q30;
    cy = 0;
    cz = r;
    for (int i = 0; i < 31; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - ARCTAN_STEP[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + ARCTAN_STEP[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    s = cy;
    c = cx;
  endfunction

  // a*p + b*q back to Q16.16, round half up, saturate
  function automatic vaxr_pkg::q16_t turn_pair(input longint a, input longint p,
                                               input longint b, input longint q);
    longint acc;
    acc = (a * p + b * q + ROUND_HALF) >>> 30;
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    return acc[31:0];
  endfunction

  function automatic vec3_t rotate_request(input logic [1:0] cmd,
                                           input vaxr_pkg::q16_t x,
                                           input vaxr_pkg::q16_t y,
                                           input vaxr_pkg::q16_t z,
                                           input vaxr_pkg::q16_t angle);
    longint s, c, lx, ly, lz;
    vec3_t  v;
    sine_cosine(angle, s, c);
    lx = x;
    ly = y;
    lz = z;
    v.x = x;
    v.y = y;
    v.z = z;
    case (cmd)
      vaxr_pkg::CMD_ROT_X: begin
        v.y = turn_pair(ly, c, lz, -s);
        v.z = turn_pair(ly, s, lz, c);
      end
      vaxr_pkg::CMD_ROT_Y: begin
        v.x = turn_pair(lx, c, lz, s);
        v.z = turn_pair(lx, -s, lz, c);
      end
      vaxr_pkg::CMD_ROT_Z: begin
        v.x = turn_pair(lx, c, ly, -s);
        v.y = turn_pair(lx, s, ly, c);
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    vec3_t want;
    if (rst) begin
      expected_vectors.delete();
      errs    = 0;
      checked = 0;
      rails   = 0;
    end else begin
      // results are checked before this edge's request is queued
      if (res_valid && res_ready) begin
        if (expected_vectors.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("[%0t] result with nothing outstanding: %0d %0d %0d", $realtime,
                     x_out, y_out, z_out);
        end else begin
          want = expected_vectors.pop_front();
          checked++;
          if (want.x !== x_out || want.y !== y_out || want.z !== z_out) begin
            errs++;
            if (errs <= 10)
              $display("[%0t] result %0d: x exp %0d got %0d, y exp %0d got %0d, %s%0d got %0d",
                       $realtime, checked, $signed(want.x), x_out, $signed(want.y), y_out,
                       "z exp ", $signed(want.z), z_out);
          end
        end
      end
      if (req_valid && req_ready) begin
        want = rotate_request(command, x_in, y_in, z_in, angle_rad);
        if (want.x == RAIL_HI || want.x == RAIL_LO || want.y == RAIL_HI ||
            want.y == RAIL_LO || want.z == RAIL_HI || want.z == RAIL_LO)
          rails++;
        expected_vectors.push_back(want);
      end
    end
    mismatch_count  <= errs;
    pending         <= expected_vectors.size();
    results_checked <= checked;
    rail_results    <= rails;
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the axis rotation core. Prediction and compare
// live in rotation_checker, which sits beside the core on the same wires.
module tb_top;

  // Slowest legal run is roughly 1100 requests, each with the longest idle gap
  // and stall, plus the 40-stage fill; the limit is many times that.
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int DRAIN_CYCLES    = 60;     // comfortably past the 40-deep pipe
  localparam int RANDOM_REQUESTS = 1100;

  // handy Q16.16 values
  localparam vaxr_pkg::q16_t Q_MAX        = 32'sh7FFF_FFFF;
  localparam vaxr_pkg::q16_t Q_MIN        = 32'sh8000_0000;
  localparam vaxr_pkg::q16_t Q_ONE        = 32'sd65536;
  localparam vaxr_pkg::q16_t EIGHTH_TURN  = 32'sd51472;    // pi/4
  localparam vaxr_pkg::q16_t QUARTER_TURN = 32'sd102944;   // pi/2
  localparam vaxr_pkg::q16_t HALF_TURN    = 32'sd205887;   // pi
  localparam vaxr_pkg::q16_t FULL_TURN    = 32'sd411775;   // 2pi

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic [1:0]     command   = vaxr_pkg::CMD_ROT_X;
  vaxr_pkg::q16_t x_in      = '0;
  vaxr_pkg::q16_t y_in      = '0;
  vaxr_pkg::q16_t z_in      = '0;
  vaxr_pkg::q16_t angle_rad = '0;
  logic           res_ready = 1'b0;
  logic           req_ready;
  logic           res_valid;
  vaxr_pkg::q16_t x_out;
  vaxr_pkg::q16_t y_out;
  vaxr_pkg::q16_t z_out;

  int mismatch_count;
  int pending;
  int results_checked;
  int rail_results;
  int cycle_count    = 0;
  int axis_count [4] = '{0, 0, 0, 0};
  int calm_tx        = 0;   // requests left in a no-idle stretch (sender)
  int calm_rx        = 0;   // results left in a no-stall stretch (receiver)

  always #5 clk = ~clk;

  vector_axis_rotation_core u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .command  (command),
    .x_in     (x_in),
    .y_in     (y_in),
    .z_in     (z_in),
    .angle_rad(angle_rad),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .x_out    (x_out),
    .y_out    (y_out),
    .z_out    (z_out)
  );

  rotation_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .command        (command),
    .x_in           (x_in),
    .y_in           (y_in),
    .z_in           (z_in),
    .angle_rad      (angle_rad),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .x_out          (x_out),
    .y_out          (y_out),
    .z_out          (z_out),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .results_checked(results_checked),
    .rail_results   (rail_results)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Idle/stall length per item is drawn at random, with occasional stretches of
  // back-to-back traffic so the pipe also runs full and drains at full rate.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(16, 64);
    return $urandom_range(0, 12);
  endfunction

  // Entered right after the previous request was taken (or after a pause
  // that already dropped valid). Valid is only lowered when a gap is drawn,
  // so back-to-back requests never see a low/high pair in one time step.
  task automatic send_rotation(input logic [1:0] cmd, input vaxr_pkg::q16_t x,
                               input vaxr_pkg::q16_t y, input vaxr_pkg::q16_t z,
                               input vaxr_pkg::q16_t ang);
    int gap;
    gap = draw_wait(calm_tx);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command   <= cmd;
    x_in      <= x;
    y_in      <= y;
    z_in      <= z;
    angle_rad <= ang;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    axis_count[cmd]++;
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Random field values lean on the interesting regions: rails, full-range
  // noise, and moderate magnitudes that rotate without saturating.
  function automatic vaxr_pkg::q16_t pick_component();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3, 4: return vaxr_pkg::q16_t'($urandom);
      default: return vaxr_pkg::q16_t'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    endcase
  endfunction

  function automatic vaxr_pkg::q16_t pick_angle();
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    k   = int'($urandom_range(0, 16)) - 8;
    case (sel)
      0, 1:    return vaxr_pkg::q16_t'($urandom);
      // near a multiple of pi/2, where the quadrant fold switches
      2, 3:    return k * QUARTER_TURN + (int'($urandom_range(0, 4)) - 2);
      default: return vaxr_pkg::q16_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic [1:0] pick_command();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0, 1:    return vaxr_pkg::CMD_ROT_X;
      2, 3:    return vaxr_pkg::CMD_ROT_Y;
      4, 5, 6: return vaxr_pkg::CMD_ROT_Z;
      default: return vaxr_pkg::CMD_NONE;
    endcase
  endfunction

  // Result side: stall a random number of cycles per result, then take it.
  initial begin
    wait (!rst);
    forever begin
      int stall;
      stall = draw_wait(calm_rx);
      @(negedge clk);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  initial begin
    // reset held from time zero, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero vector, quarter and half turns across the axes, the
    // pass-through command, saturation on both rails, angle extremes and
    // the pi and pi/2 fold boundaries.
    send_rotation(vaxr_pkg::CMD_ROT_X, '0, '0, '0, '0);
    send_rotation(vaxr_pkg::CMD_ROT_X, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, QUARTER_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_Y, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, HALF_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_Z, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, -QUARTER_TURN);
    send_rotation(vaxr_pkg::CMD_NONE, Q_MAX, Q_MIN, Q_MAX, EIGHTH_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_Z, Q_MAX, Q_MAX, Q_ONE, EIGHTH_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_Z, Q_MIN, Q_MIN, Q_ONE, EIGHTH_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_X, Q_ONE, Q_MAX, Q_MIN, -EIGHTH_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_Y, Q_MIN, Q_ONE, Q_MAX, 3 * EIGHTH_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_X, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_MAX);
    send_rotation(vaxr_pkg::CMD_ROT_Y, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_MIN);
    send_rotation(vaxr_pkg::CMD_ROT_Z, Q_MAX, Q_MIN, Q_ONE, -32'sd1);
    send_rotation(vaxr_pkg::CMD_ROT_Z, Q_MAX, Q_MIN, Q_ONE, 32'sd1);
    send_rotation(vaxr_pkg::CMD_ROT_X, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, FULL_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_Y, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, HALF_TURN + 1);
    send_rotation(vaxr_pkg::CMD_ROT_Z, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, -HALF_TURN);
    send_rotation(vaxr_pkg::CMD_ROT_X, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, QUARTER_TURN - 1);
    send_rotation(vaxr_pkg::CMD_ROT_Y, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, QUARTER_TURN + 1);
    send_rotation(vaxr_pkg::CMD_ROT_Z, 32'sd1, -32'sd1, 32'sd1, 3 * QUARTER_TURN);
    send_rotation(vaxr_pkg::CMD_NONE, '0, '0, '0, Q_MIN);
    send_rotation(vaxr_pkg::CMD_ROT_Z, Q_MAX, '0, Q_MIN, '0);
    send_rotation(vaxr_pkg::CMD_ROT_X, -32'sd1, -32'sd1, -32'sd1, QUARTER_TURN);

    // let the pipe empty completely before the random traffic
    drain_results();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) drain_results();
      send_rotation(pick_command(), pick_component(), pick_component(), pick_component(),
                    pick_angle());
    end

    drain_results();
    // anything the core emits past this point is an extra result
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests: %0d about x, %0d about y, %0d about z, %0d pass-through",
             axis_count[0] + axis_count[1] + axis_count[2] + axis_count[3],
             axis_count[vaxr_pkg::CMD_ROT_X], axis_count[vaxr_pkg::CMD_ROT_Y],
             axis_count[vaxr_pkg::CMD_ROT_Z], axis_count[vaxr_pkg::CMD_NONE]);
    $display("checked %0d results, %0d with a component at a rail, %0d mismatches",
             results_checked, rail_results, mismatch_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
